// File: rtl/mbb_pkg.sv
// Shared types, register indexes and codes for the masked bitmap blit.
package mbb_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_FRAME_BASE        = 3'd0,
        REG_DEST_PITCH        = 3'd1,
        REG_PIXEL_FORMAT      = 3'd2,
        REG_PLACEMENT         = 3'd3,
        REG_RECT_LEFT_TOP     = 3'd4,
        REG_RECT_RIGHT_BOTTOM = 3'd5,
        REG_IMAGE_WIDTH       = 3'd6,
        REG_IMAGE_HEIGHT      = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_MASKED  = 2'd1,
        ST_OOB     = 2'd2,
        ST_UNSUP   = 2'd3
    } t_status;

    localparam logic [1:0] FMT_PAL8  = 2'd0;
    localparam logic [1:0] FMT_RGB32 = 2'd1;

    localparam logic [1:0] BC_NONE = 2'd0;
    localparam logic [1:0] BC_PAL8 = 2'd1;
    localparam logic [1:0] BC_RGB  = 2'd3;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [17:0] dest_pitch;
        logic [1:0]  pixel_format;
        logic [31:0] placement;
        logic [31:0] rect_left_top;
        logic [31:0] rect_right_bottom;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_cfg;

    // Classified pixel handed from the front end to the back end.
    typedef struct packed {
        logic [23:0]      data;
        logic [1:0]       count;
        t_status          status;
        logic             last;
        logic             col0;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
    } t_cmd;

    // Scale a byte offset by the pixel size of the format.
    function automatic logic [31:0] scale_bpp(input logic [31:0] v, input logic [1:0] fmt);
        return (fmt == FMT_RGB32) ? {v[29:0], 2'b00} : v;
    endfunction

endpackage

// File: rtl/mbb_pix_if.sv
// Source pixel channel: valid/ready with one pixel per beat.
interface mbb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       mask_bit;

    modport source (output valid, palette_index, red, green, blue, mask_bit, input ready);
    modport sink   (input valid, palette_index, red, green, blue, mask_bit, output ready);
endinterface

// File: rtl/mbb_wr_if.sv
// Write descriptor channel: valid/ready with one descriptor per beat.
interface mbb_wr_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_address;
    logic [23:0] write_data;
    logic [1:0]  byte_count;
    logic [1:0]  status;
    logic        last_pixel;

    modport source (output valid, write_address, write_data, byte_count, status, last_pixel,
                    input ready);
    modport sink   (input valid, write_address, write_data, byte_count, status, last_pixel,
                    output ready);
endinterface

// File: rtl/masked_bitmap_blit_top.sv
// Top level of the masked bitmap blit: register file, front end, queue, back end.
//
// Takes a raster-order pixel stream and emits one write descriptor per pixel,
// in order, at a sustained rate of one pixel per clock while the receiver
// keeps ready high. The front end keeps the column and row counters and
// classifies each pixel (written, masked, out of bounds, unsupported format)
// against the live registers; a two-entry queue decouples it from the back
// end, a four-stage pipeline that forms the byte address: offsets, one 32x18
// multiply of the destination row by the pitch, the row start add, then the
// column add into the output register. The row start is taken at the first
// pixel of each row and held for that row. Widths and heights above 4096
// saturate to 4096; a zero width or height gives an out-of-bounds,
// last-pixel descriptor for every pixel.
// Write registers only while no pixel is in flight; writes leave the
// counters untouched.
module masked_bitmap_blit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mbb_pix_if.sink     i_pix,
    mbb_wr_if.source    o_wr
);
    import mbb_pkg::*;

    t_cfg r_cfg;
    logic q_ready, q_push, q_valid, q_pop;
    t_cmd push_cmd, pop_cmd;

    // Register file: one write per beat of the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FRAME_BASE:        r_cfg.frame_base        <= i_cfg_data;
                REG_DEST_PITCH:        r_cfg.dest_pitch        <= i_cfg_data[17:0];
                REG_PIXEL_FORMAT:      r_cfg.pixel_format      <= i_cfg_data[1:0];
                REG_PLACEMENT:         r_cfg.placement         <= i_cfg_data;
                REG_RECT_LEFT_TOP:     r_cfg.rect_left_top     <= i_cfg_data;
                REG_RECT_RIGHT_BOTTOM: r_cfg.rect_right_bottom <= i_cfg_data;
                REG_IMAGE_WIDTH:       r_cfg.image_width       <= i_cfg_data[12:0];
                REG_IMAGE_HEIGHT:      r_cfg.image_height      <= i_cfg_data[12:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Classify and count pixels; stall only when the queue is full.
    mbb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_pix     (i_pix),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_cmd   (push_cmd)
    );

    mbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd)
    );

    // Form addresses and hold each descriptor until its beat is taken.
    mbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (pop_cmd),
        .o_q_pop   (q_pop),
        .o_wr      (o_wr)
    );

endmodule

// File: rtl/mbb_front.sv
// Front end: raster counters, bounds and format checks, pixel classification.
module mbb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbb_pkg::t_cfg  i_cfg,
    mbb_pix_if.sink        i_pix,
    input  logic           i_q_ready,
    output logic           o_q_push,
    output mbb_pkg::t_cmd  o_q_cmd
);
    import mbb_pkg::*;

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;

    logic [DIM_W-1:0] w, h;
    logic             empty;
    logic             oob;
    logic [18:0]      x_end, y_end;
    logic             col_end, row_end;
    t_status          status;

    always_comb begin
        w = (i_cfg.image_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.image_width;
        h = (i_cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.image_height;
        empty = (w == '0) || (h == '0);

        x_end = {{3{i_cfg.placement[15]}}, i_cfg.placement[15:0]} + 19'(w);
        y_end = {{3{i_cfg.placement[31]}}, i_cfg.placement[31:16]} + 19'(h);
        oob = i_cfg.placement[15] || i_cfg.placement[31]
            || ($signed(x_end) > $signed({{3{i_cfg.rect_right_bottom[15]}},
                                          i_cfg.rect_right_bottom[15:0]}))
            || ($signed(y_end) > $signed({{3{i_cfg.rect_right_bottom[31]}},
                                          i_cfg.rect_right_bottom[31:16]}));

        if (oob || empty) begin
            status = ST_OOB;
        end else if (i_cfg.pixel_format > FMT_RGB32) begin
            status = ST_UNSUP;
        end else if (!i_pix.mask_bit) begin
            status = ST_MASKED;
        end else begin
            status = ST_WRITTEN;
        end

        col_end = ({1'b0, r_col} + DIM_W'(1)) >= w;
        row_end = ({1'b0, r_row} + DIM_W'(1)) >= h;

        o_q_cmd.status = status;
        o_q_cmd.col    = r_col;
        o_q_cmd.row    = r_row;
        o_q_cmd.col0   = !empty && (r_col == '0);
        o_q_cmd.data   = '0;
        o_q_cmd.count  = BC_NONE;
        if (status == ST_WRITTEN) begin
            if (i_cfg.pixel_format == FMT_PAL8) begin
                o_q_cmd.data  = {16'h0000, i_pix.palette_index};
                o_q_cmd.count = BC_PAL8;
            end else begin
                o_q_cmd.data  = {i_pix.blue, i_pix.green, i_pix.red};
                o_q_cmd.count = BC_RGB;
            end
        end

        // Advance the raster position; wrap at row and image end.
        n_col = r_col;
        n_row = r_row;
        o_q_cmd.last = 1'b0;
        if (empty) begin
            n_col = '0;
            n_row = '0;
            o_q_cmd.last = 1'b1;
        end else if (col_end) begin
            n_col = '0;
            if (row_end) begin
                n_row = '0;
                o_q_cmd.last = 1'b1;
            end else begin
                n_row = r_row + CNT_W'(1);
            end
        end else begin
            n_col = r_col + CNT_W'(1);
        end
    end

    assign i_pix.ready = i_q_ready;
    assign o_q_push    = i_pix.valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_q_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: rtl/mbb_queue.sv
// Short command queue between front and back end.
module mbb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbb_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output mbb_pkg::t_cmd o_cmd
);
    import mbb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push, do_pop;

    assign o_ready = (r_count != CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

// File: rtl/mbb_back.sv
// Back end: four-stage address pipeline ending in the output register.
module mbb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mbb_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  mbb_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    mbb_wr_if.source      o_wr
);
    import mbb_pkg::*;

    logic        r_v1, r_v2, r_v3, r_v4;
    t_cmd        r_c1, r_c2, r_c3;
    logic [31:0] r_yrow1, r_xbase1;
    logic [31:0] r_prod2, r_xbase2;
    logic [31:0] r_rs3;
    logic [31:0] r_row_start;

    logic [31:0] r_addr;
    logic [23:0] r_data;
    logic [1:0]  r_count;
    t_status     r_status;
    logic        r_last;

    logic        rdy1, rdy2, rdy3, rdy4;
    logic [31:0] xoff, yoff, rs, col_off;

    assign rdy4 = !r_v4 || o_wr.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_q_pop = i_q_valid && rdy1;

    always_comb begin
        xoff = {{16{i_cfg.placement[15]}}, i_cfg.placement[15:0]}
             - {{16{i_cfg.rect_left_top[15]}}, i_cfg.rect_left_top[15:0]};
        yoff = {{16{i_cfg.placement[31]}}, i_cfg.placement[31:16]}
             - {{16{i_cfg.rect_left_top[31]}}, i_cfg.rect_left_top[31:16]};
        rs = r_c2.col0 ? (r_xbase2 + r_prod2) : r_row_start;
        col_off = scale_bpp(32'(r_c3.col), i_cfg.pixel_format);
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_row_start <= '0;
        end else begin
            if (rdy1) r_v1 <= i_q_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            // Latch the row start when the first pixel of a row passes.
            if (rdy3 && r_v2 && r_c2.col0) r_row_start <= rs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_q_valid) begin
            r_c1     <= i_q_cmd;
            r_yrow1  <= yoff + 32'(i_q_cmd.row);
            r_xbase1 <= i_cfg.frame_base + scale_bpp(xoff, i_cfg.pixel_format);
        end
        if (rdy2 && r_v1) begin
            r_c2     <= r_c1;
            r_prod2  <= 32'(r_yrow1 * {14'b0, i_cfg.dest_pitch});
            r_xbase2 <= r_xbase1;
        end
        if (rdy3 && r_v2) begin
            r_c3  <= r_c2;
            r_rs3 <= rs;
        end
        if (rdy4 && r_v3) begin
            r_addr   <= (r_c3.status == ST_WRITTEN) ? (r_rs3 + col_off) : '0;
            r_data   <= r_c3.data;
            r_count  <= r_c3.count;
            r_status <= r_c3.status;
            r_last   <= r_c3.last;
        end
    end

    assign o_wr.valid         = r_v4;
    assign o_wr.write_address = r_addr;
    assign o_wr.write_data    = r_data;
    assign o_wr.byte_count    = r_count;
    assign o_wr.status        = r_status;
    assign o_wr.last_pixel    = r_last;

endmodule

// File: tb/tb_top.sv
// Testbench for the masked bitmap blit: directed table, random images, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import mbb_pkg::*;

    // Format codes that the block must report as unsupported.
    localparam logic [1:0] FMT_RSVD2 = 2'd2;
    localparam logic [1:0] FMT_RSVD3 = 2'd3;

    localparam int RANDOM_PIXELS = 1750;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills queue and pipe
    localparam int STALL_LIMIT   = 2000;  // cycles without a beat or register write before giving up
    localparam int DRAIN_CYCLES  = 12;    // idle margin after the final drain, to catch stray beats

    typedef struct packed {
        logic [7:0] pal;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       mask;
    } t_pixel;

    typedef struct packed {
        logic [31:0] addr;
        logic [23:0] data;
        logic [1:0]  count;
        logic [1:0]  status;
        logic        last;
    } t_desc;

    // One line of the directed table: optional register load, then one pixel.
    // Where typed is set, want holds the descriptor worked out by hand.
    typedef struct packed {
        logic   has_cfg;
        t_cfg   cfg;
        logic   typed;
        t_pixel pix;
        t_desc  want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    mbb_pix_if pix_ch ();
    mbb_wr_if  wr_ch ();

    masked_bitmap_blit_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch.sink),
        .o_wr       (wr_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Blit predictor: a private copy of the registers and the raster state
    // ------------------------------------------------------------------
    t_cfg        blit_regs;
    int          col_cnt;
    int          row_cnt;
    logic [31:0] row_base;

    t_desc       pending_writes[$];
    int          n_fail;
    int          n_sent;

    logic        tx_quiet;      // sender offers back-to-back beats
    logic        rx_quiet;      // receiver keeps ready high
    logic        rx_hold_req;   // ask the receiver for one long hold-off

    t_dir_row    dir_rows[$];
    logic        next_has_cfg;
    t_cfg        next_cfg;

    // Work out the descriptor for one pixel and advance the raster counters.
    function automatic t_desc blit_pixel(t_pixel p);
        int          w;
        int          h;
        int          x;
        int          y;
        int          lft;
        int          tp;
        int          rgt;
        int          btm;
        logic [31:0] bpp;
        t_desc       d;
        w   = (blit_regs.image_width > MAX_DIM) ? MAX_DIM : int'(blit_regs.image_width);
        h   = (blit_regs.image_height > MAX_DIM) ? MAX_DIM : int'(blit_regs.image_height);
        x   = int'($signed(blit_regs.placement[15:0]));
        y   = int'($signed(blit_regs.placement[31:16]));
        lft = int'($signed(blit_regs.rect_left_top[15:0]));
        tp  = int'($signed(blit_regs.rect_left_top[31:16]));
        rgt = int'($signed(blit_regs.rect_right_bottom[15:0]));
        btm = int'($signed(blit_regs.rect_right_bottom[31:16]));
        bpp = (blit_regs.pixel_format == FMT_RGB32) ? 32'd4 : 32'd1;
        d   = '0;

        // Empty image: every pixel is its own out-of-bounds last pixel.
        if (w == 0 || h == 0) begin
            col_cnt  = 0;
            row_cnt  = 0;
            d.status = ST_OOB;
            d.last   = 1'b1;
            return d;
        end

        // Latch the row start at column zero; all sums wrap at 32 bits.
        if (col_cnt == 0) begin
            row_base = blit_regs.frame_base + 32'(x - lft) * bpp
                     + (32'(y - tp) + 32'(row_cnt)) * 32'(blit_regs.dest_pitch);
        end

        if (x < 0 || y < 0 || x + w > rgt || y + h > btm) begin
            d.status = ST_OOB;
        end else if (blit_regs.pixel_format != FMT_PAL8 &&
                     blit_regs.pixel_format != FMT_RGB32) begin
            d.status = ST_UNSUP;
        end else if (!p.mask) begin
            d.status = ST_MASKED;
        end else begin
            d.status = ST_WRITTEN;
            d.addr   = row_base + 32'(col_cnt) * bpp;
            if (blit_regs.pixel_format == FMT_PAL8) begin
                d.data  = {16'h0000, p.pal};
                d.count = BC_PAL8;
            end else begin
                d.data  = {p.blue, p.green, p.red};
                d.count = BC_RGB;
            end
        end

        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            if (row_cnt + 1 >= h) begin
                row_cnt = 0;
                d.last  = 1'b1;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Builders for table rows and register sets
    // ------------------------------------------------------------------
    function automatic t_cfg mk_cfg(logic [31:0] base, logic [17:0] pitch, logic [1:0] fmt,
                                    logic [31:0] place, logic [31:0] lt, logic [31:0] rb,
                                    logic [12:0] w, logic [12:0] h);
        t_cfg c;
        c.frame_base        = base;
        c.dest_pitch        = pitch;
        c.pixel_format      = fmt;
        c.placement         = place;
        c.rect_left_top     = lt;
        c.rect_right_bottom = rb;
        c.image_width       = w;
        c.image_height      = h;
        return c;
    endfunction

    function automatic t_pixel mk_pix(logic [7:0] pal, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, logic m);
        t_pixel p;
        p.pal   = pal;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.mask  = m;
        return p;
    endfunction

    function automatic t_desc mk_desc(logic [31:0] a, logic [23:0] dat, logic [1:0] bc,
                                      t_status st, logic lst);
        t_desc d;
        d.addr   = a;
        d.data   = dat;
        d.count  = bc;
        d.status = st;
        d.last   = lst;
        return d;
    endfunction

    function automatic t_pixel rand_pix();
        return mk_pix(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(0, 4) != 0);
    endfunction

    // Random register set: mostly small images placed inside the rectangle,
    // some placed one pixel over an edge, some fully random, a few empty or
    // oversized, and an unsupported format now and then.
    function automatic t_cfg rand_cfg();
        t_cfg c;
        int   w;
        int   h;
        int   wc;
        int   hc;
        int   x;
        int   y;
        int   pick;
        c.frame_base = $urandom;
        c.dest_pitch = 18'($urandom);
        pick = $urandom_range(0, 9);
        c.pixel_format = (pick < 4) ? FMT_PAL8 : (pick < 8) ? FMT_RGB32 :
                         (pick == 8) ? FMT_RSVD2 : FMT_RSVD3;
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w = 0;
        end else if (pick == 1) begin
            h = 0;
        end else if (pick == 2) begin
            w = $urandom_range(MAX_DIM + 1, 8191);
        end else if (pick == 3) begin
            h = $urandom_range(MAX_DIM + 1, 8191);
        end
        wc = (w > MAX_DIM) ? MAX_DIM : w;
        hc = (h > MAX_DIM) ? MAX_DIM : h;
        x  = $urandom_range(0, 40);
        y  = $urandom_range(0, 40);
        c.placement     = {16'(y), 16'(x)};
        c.rect_left_top = $urandom;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            c.placement         = $urandom;
            c.rect_right_bottom = $urandom;
        end else if (pick == 1) begin
            c.rect_right_bottom = {16'(y + hc), 16'(x + wc - 1)};
        end else if (pick == 2) begin
            c.rect_right_bottom = {16'(y + hc - 1), 16'(x + wc)};
        end else begin
            c.rect_right_bottom = {16'(y + hc + int'($urandom_range(0, 3))),
                                   16'(x + wc + int'($urandom_range(0, 3)))};
        end
        c.image_width  = 13'(w);
        c.image_height = 13'(h);
        return c;
    endfunction

    task automatic plan_cfg(t_cfg c);
        next_cfg     = c;
        next_has_cfg = 1'b1;
    endtask

    task automatic plan_pix(t_pixel p, logic typed, t_desc want);
        t_dir_row r;
        r.has_cfg    = next_has_cfg;
        r.cfg        = next_cfg;
        r.typed      = typed;
        r.pix        = p;
        r.want       = want;
        next_has_cfg = 1'b0;
        dir_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic set_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Load every register; call only with nothing in flight.
    task automatic load_cfg(t_cfg c);
        set_reg(REG_FRAME_BASE,        c.frame_base);
        set_reg(REG_DEST_PITCH,        32'(c.dest_pitch));
        set_reg(REG_PIXEL_FORMAT,      32'(c.pixel_format));
        set_reg(REG_PLACEMENT,         c.placement);
        set_reg(REG_RECT_LEFT_TOP,     c.rect_left_top);
        set_reg(REG_RECT_RIGHT_BOTTOM, c.rect_right_bottom);
        set_reg(REG_IMAGE_WIDTH,       32'(c.image_width));
        set_reg(REG_IMAGE_HEIGHT,      32'(c.image_height));
        i_cfg_we  <= 1'b0;
        blit_regs = c;
    endtask

    // Offer one pixel after a random gap and hold it until the beat is taken.
    task automatic send_pixel(t_pixel p, logic typed, t_desc want);
        int    gap;
        t_desc pred;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid         <= 1'b1;
        pix_ch.palette_index <= p.pal;
        pix_ch.red           <= p.red;
        pix_ch.green         <= p.green;
        pix_ch.blue          <= p.blue;
        pix_ch.mask_bit      <= p.mask;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        // Always run the predictor so its counters track the block.
        pred = blit_pixel(p);
        pending_writes.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // Drop valid and wait until every descriptor in flight has come back.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row row;
        t_cfg     c;
        int       n;
        int       area;
        int       phase;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_FRAME_BASE;
        i_cfg_data           = '0;
        pix_ch.valid         = 1'b0;
        pix_ch.palette_index = '0;
        pix_ch.red           = '0;
        pix_ch.green         = '0;
        pix_ch.blue          = '0;
        pix_ch.mask_bit      = 1'b0;
        tx_quiet             = 1'b0;
        rx_quiet             = 1'b0;
        rx_hold_req          = 1'b0;
        blit_regs            = '0;
        col_cnt              = 0;
        row_cnt              = 0;
        row_base             = '0;
        n_fail               = 0;
        n_sent               = 0;
        next_has_cfg         = 1'b0;
        next_cfg             = '0;

        // Directed table.
        // Out of reset every register is zero: empty image, out of bounds, last.
        plan_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_OOB, 1'b1));

        // 2x2 palette image at (2,3), pitch 0x40: row starts at 0x10C2, 0x1102.
        plan_cfg(mk_cfg(32'h1000, 18'h40, FMT_PAL8, {16'd3, 16'd2}, 32'h0,
                        {16'd16, 16'd16}, 13'd2, 13'd2));
        plan_pix(mk_pix(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
                 mk_desc(32'h10C2, 24'h0000FF, BC_PAL8, ST_WRITTEN, 1'b0));
        plan_pix(mk_pix(8'h5A, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_MASKED, 1'b0));
        plan_pix(mk_pix(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1,
                 mk_desc(32'h1102, 24'h000000, BC_PAL8, ST_WRITTEN, 1'b0));
        plan_pix(mk_pix(8'h80, 8'h12, 8'h34, 8'h56, 1'b1), 1'b0, '0);

        // Same image in RGB32: four bytes per pixel, row start 0x10C8.
        plan_cfg(mk_cfg(32'h1000, 18'h40, FMT_RGB32, {16'd3, 16'd2}, 32'h0,
                        {16'd16, 16'd16}, 13'd2, 13'd2));
        plan_pix(mk_pix(8'h00, 8'hFF, 8'h00, 8'hAA, 1'b1), 1'b1,
                 mk_desc(32'h10C8, 24'hAA00FF, BC_RGB, ST_WRITTEN, 1'b0));
        plan_pix(mk_pix(8'hFF, 8'h00, 8'hFF, 8'h55, 1'b1), 1'b0, '0);
        plan_pix(mk_pix(8'h33, 8'h44, 8'h55, 8'h66, 1'b0), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_MASKED, 1'b0));
        plan_pix(mk_pix(8'h01, 8'h80, 8'h7F, 8'h01, 1'b1), 1'b0, '0);

        // Unsupported formats; the format wins over a cleared mask.
        plan_cfg(mk_cfg(32'h2000, 18'h10, FMT_RSVD2, {16'd1, 16'd1}, 32'h0,
                        {16'd8, 16'd8}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'hA5, 8'hA5, 8'hA5, 8'hA5, 1'b1), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_UNSUP, 1'b1));
        plan_cfg(mk_cfg(32'h2000, 18'h10, FMT_RSVD3, {16'd1, 16'd1}, 32'h0,
                        {16'd8, 16'd8}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'h5A, 8'h5A, 8'h5A, 8'h5A, 1'b0), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_UNSUP, 1'b1));

        // Out of bounds on each side; it outranks format and mask.
        plan_cfg(mk_cfg(32'h3000, 18'h20, FMT_RSVD3, {16'd0, 16'hFFFF}, 32'h0,
                        {16'd16, 16'd16}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'h11, 8'h22, 8'h33, 8'h44, 1'b0), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_OOB, 1'b1));
        plan_cfg(mk_cfg(32'h3000, 18'h20, FMT_PAL8, {16'hFFFF, 16'd0}, 32'h0,
                        {16'd16, 16'd16}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'h11, 8'h22, 8'h33, 8'h44, 1'b1), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_OOB, 1'b1));
        plan_cfg(mk_cfg(32'h3000, 18'h20, FMT_PAL8, {16'd0, 16'd16}, 32'h0,
                        {16'd16, 16'd16}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'h11, 8'h22, 8'h33, 8'h44, 1'b1), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_OOB, 1'b1));
        plan_cfg(mk_cfg(32'h3000, 18'h20, FMT_PAL8, {16'd16, 16'd0}, 32'h0,
                        {16'd16, 16'd16}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'h11, 8'h22, 8'h33, 8'h44, 1'b1), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_OOB, 1'b1));
        // Flush against the right and bottom edges is still inside.
        plan_cfg(mk_cfg(32'h3000, 18'h20, FMT_PAL8, {16'd15, 16'd15}, 32'h0,
                        {16'd16, 16'd16}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'hC3, 8'h22, 8'h33, 8'h44, 1'b1), 1'b0, '0);

        // Largest base, pitch and offsets: the address wraps at 32 bits.
        plan_cfg(mk_cfg(32'hFFFF_FFFF, 18'h3FFFF, FMT_RGB32, {16'h7FFE, 16'h7FFE},
                        {16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF}, 13'd1, 13'd1));
        plan_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0, '0);

        // Oversized image saturates to 4096, so it just fits a 4096 rectangle.
        plan_cfg(mk_cfg(32'h0, 18'h3FFFF, FMT_PAL8, 32'h0, 32'h0,
                        {16'd4096, 16'd4096}, 13'h1FFF, 13'h1FFF));
        plan_pix(mk_pix(8'h01, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0);
        plan_pix(mk_pix(8'h02, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0);
        plan_pix(mk_pix(8'h03, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0);

        // Zero width with counters mid-image: out of bounds, last, counters clear.
        plan_cfg(mk_cfg(32'h4000, 18'h8, FMT_PAL8, 32'h0, 32'h0,
                        {16'd16, 16'd16}, 13'd0, 13'd5));
        plan_pix(mk_pix(8'h77, 8'h77, 8'h77, 8'h77, 1'b1), 1'b1,
                 mk_desc(32'h0, 24'h0, BC_NONE, ST_OOB, 1'b1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; registers change only once the pipe is empty.
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.has_cfg) begin
                drain();
                load_cfg(row.cfg);
            end
            send_pixel(row.pix, row.typed, row.want);
        end

        // Random images until the pixel budget is spent.
        phase = 0;
        n_sent = 0;
        while (n_sent < RANDOM_PIXELS) begin
            drain();
            c = rand_cfg();
            load_cfg(c);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            area = int'(c.image_width) * int'(c.image_height);
            if (area == 0) begin
                n = $urandom_range(1, 4);
            end else if (c.image_width > MAX_DIM || c.image_height > MAX_DIM) begin
                n = $urandom_range(5, 30);
            end else if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, area + 3);      // cut short or run over
            end else begin
                n = area * $urandom_range(1, 3);      // whole images
            end
            // Twice in the run: hold off the receiver while pixels keep coming.
            if (phase == 3 || phase == 25) begin
                rx_hold_req = 1'b1;
                tx_quiet    = 1'b1;
                if (n < 40) n = 40;
            end
            repeat (n) send_pixel(rand_pix(), 1'b0, '0);
            phase++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && pending_writes.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, quiet stretches, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall;
        int hold_left;
        wr_ch.ready = 1'b0;
        forever begin
            if (rx_hold_req) begin
                wr_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
                rx_hold_req = 1'b0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                wr_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            wr_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!wr_ch.valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: compare each write beat against the oldest expectation
    // ------------------------------------------------------------------
    t_desc got;
    t_desc want;

    always @(posedge i_clk) begin
        if (i_rst_n && wr_ch.valid && wr_ch.ready) begin
            got.addr   = wr_ch.write_address;
            got.data   = wr_ch.write_data;
            got.count  = wr_ch.byte_count;
            got.status = wr_ch.status;
            got.last   = wr_ch.last_pixel;
            if (pending_writes.size() == 0) begin
                $error("unexpected write beat: address %h status %0d", got.addr, got.status);
                n_fail++;
            end else begin
                want = pending_writes.pop_front();
                if (got.addr !== want.addr) begin
                    $error("write_address: expected %h, got %h", want.addr, got.addr);
                    n_fail++;
                end
                if (got.data !== want.data) begin
                    $error("write_data: expected %h, got %h", want.data, got.data);
                    n_fail++;
                end
                if (got.count !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count, got.count);
                    n_fail++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_fail++;
                end
                if (got.last !== want.last) begin
                    $error("last_pixel: expected %0d, got %0d", want.last, got.last);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: any beat or register write counts as progress.
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (pix_ch.valid && pix_ch.ready) ||
            (wr_ch.valid && wr_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule

// File: filelist.f
rtl/mbb_pkg.sv
rtl/mbb_pix_if.sv
rtl/mbb_wr_if.sv
rtl/mbb_front.sv
rtl/mbb_queue.sv
rtl/mbb_back.sv
rtl/masked_bitmap_blit_top.sv
tb/tb_top.sv
